/* hdl/fodf_pkg.sv */
// fodf_pkg: request types and probe type for the first-occurrence dedup filter.
// No dependencies; used by every file under hdl.
package fodf_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned DcntW  = 7;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic                     last_item;
  } in_req_t;

  typedef struct packed {
    logic signed [ValueW-1:0] value_out;
    logic                     keep;
    logic [DcntW-1:0]         distinct_count;
    logic                     overflow;
    logic                     last_out;
  } out_req_t;

  // Search token that walks the cell chain.
  typedef struct packed {
    logic                     valid;
    logic signed [ValueW-1:0] value;
    logic                     found;
    logic                     last;
  } probe_t;

endpackage

/* hdl/first_occurrence_dedup_filter.sv */
// first_occurrence_dedup_filter: top level, a chain of MAX_ITEMS fodf_cell
// stages plus the entry counter and output register. Depends on fodf_pkg, fodf_cell.
//
// Marks the first occurrence of each signed 32-bit value within an array.
// Every request yields one result with the value, a keep flag, the running
// distinct count and an overflow flag when the table of MAX_ITEMS entries is
// full; last_item ends the array and empties the table. One request is in
// work at a time: it walks the chain of MAX_ITEMS cells, one cell per cycle
// while the chain advances, and the next request is accepted only after it
// has left the last cell. The output register lets the next request enter
// while a result waits; a stalled result freezes the chain once the next one
// reaches its end, until the stalled one is taken. No clearing pass after reset.
module first_occurrence_dedup_filter #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  fodf_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output fodf_pkg::out_req_t out_req_o
);
  import fodf_pkg::*;

  localparam int unsigned CountW = $clog2(MAX_ITEMS + 1);
  localparam logic [CountW-1:0] CountMax = CountW'(MAX_ITEMS);

  probe_t            chain_w [MAX_ITEMS+1];
  probe_t            head_w;
  probe_t            exit_w;
  logic              adv, take, accept, add_new, ovf;
  logic              busy_d, busy_q;
  logic              out_valid_d, out_valid_q;
  out_req_t          out_req_d, out_req_q;
  logic [CountW-1:0] count_d, count_q, count_after;
  logic [CountW+DcntW-1:0] count_ext;

  assign accept = in_valid_i && !busy_q;

  always_comb begin
    head_w.valid = accept;
    head_w.value = in_req_i.value;
    head_w.found = 1'b0;
    head_w.last  = in_req_i.last_item;
  end

  assign chain_w[0] = head_w;

  for (genvar gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
    fodf_cell #(
      .CountW (CountW),
      .Idx    (gi)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .count_i (count_q),
      .probe_i (chain_w[gi]),
      .probe_o (chain_w[gi+1])
    );
  end

  assign exit_w = chain_w[MAX_ITEMS];
  assign adv    = !(exit_w.valid && out_valid_q && out_stall_i);
  assign take   = exit_w.valid && adv;

  assign add_new     = !exit_w.found && (count_q < CountMax);
  assign ovf         = !exit_w.found && !(count_q < CountMax);
  assign count_after = add_new ? count_q + CountW'(1) : count_q;
  assign count_ext   = {{DcntW{1'b0}}, count_after};

  always_comb begin
    count_d = count_q;
    if (take) begin
      count_d = exit_w.last ? '0 : count_after;
    end
  end

  always_comb begin
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (take) begin
      busy_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_req_d.value_out      = exit_w.value;
    out_req_d.keep           = !exit_w.found;
    out_req_d.distinct_count = count_ext[DcntW-1:0];
    out_req_d.overflow       = ovf;
    out_req_d.last_out       = exit_w.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_req_q <= out_req_d;
    end
  end

  assign in_stall_o  = busy_q;
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

endmodule

/* hdl/fodf_cell.sv */
// fodf_cell: one table entry of the dedup chain, compares the passing probe
// and captures it when this cell is the first free slot. Depends on fodf_pkg.
module fodf_cell #(
  parameter int unsigned CountW = 7,
  parameter int unsigned Idx    = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic [CountW-1:0]   count_i,
  input  fodf_pkg::probe_t    probe_i,
  output fodf_pkg::probe_t    probe_o
);
  import fodf_pkg::*;

  localparam logic [CountW-1:0] CellIdx = CountW'(Idx);

  logic signed [ValueW-1:0] entry_q;
  probe_t                   probe_d, probe_q;
  logic                     occupied, tail, hit, wr_en;

  assign occupied = CellIdx < count_i;
  assign tail     = CellIdx == count_i;
  assign hit      = probe_i.valid && occupied && (entry_q == probe_i.value);
  assign wr_en    = adv_i && probe_i.valid && tail && !probe_i.found;

  always_comb begin
    probe_d       = probe_i;
    probe_d.found = probe_i.found | hit;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_q <= probe_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= '0;
    end else if (adv_i) begin
      probe_q <= probe_d;
    end
  end

  assign probe_o = probe_q;

endmodule

/* hdl/fodf_checker.sv */
// fodf_checker: port-level assertions for first_occurrence_dedup_filter,
// bound to the top level below. Depends on fodf_pkg.
module fodf_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input fodf_pkg::out_req_t out_req_o
);
  import fodf_pkg::*;

  logic new_array_q;

  // Next result opens a new array.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      new_array_q <= 1'b1;
    end else if (out_valid_o && !out_stall_i) begin
      new_array_q <= out_req_o.last_out;
    end
  end

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while another is in work");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_req_o))
    else $error("stalled result dropped or changed");

  a_ovf_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_req_o.overflow && !out_req_o.keep))
    else $error("overflow on a duplicate");

  a_first_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && new_array_q |->
      out_req_o.keep && !out_req_o.overflow && (out_req_o.distinct_count == DcntW'(1)))
    else $error("first element of an array not kept");

endmodule

bind first_occurrence_dedup_filter fodf_checker u_fodf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_req_o   (out_req_o)
);
